/* src/swbe_pkg.sv */
// Shared types, constants and lookup tables for the sliding window byte entropy block.
package swbe_pkg;

  // Alphabet and window geometry
  localparam int SYMBOL_COUNT = 256;
  localparam int SYM_W        = $clog2(SYMBOL_COUNT);
  localparam int WINDOW_SIZE  = 256;
  localparam int WIN_AW       = $clog2(WINDOW_SIZE);
  localparam int FILL_W       = 9;
  localparam int CNT_W        = 9;

  // Fixed-point formats
  localparam int FRAC_W   = 16;
  localparam int ENT_W    = 20;
  localparam int DPLOG_W  = 20;
  localparam int PLOG_W   = 28;
  localparam int LLR_W    = 44;
  localparam int DIVX_W   = LLR_W - FRAC_W;
  localparam int QUO_W    = 20;
  localparam int STEP_W   = $clog2(QUO_W);
  localparam logic [ENT_W-1:0] ENTROPY_MAX = ENT_W'(524288);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    CMD_PUSH  = 1'b0,
    CMD_CLEAR = 1'b1
  } swbe_cmd_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_OLD,
    BK_NEW,
    BK_ENT,
    BK_DIV,
    BK_FIN
  } swbe_bk_state_e;

  typedef struct packed {
    logic             command;
    logic [SYM_W-1:0] data_byte;
  } swbe_in_t;

  typedef struct packed {
    logic [ENT_W-1:0]  entropy_q16;
    logic [FILL_W-1:0] window_fill;
  } swbe_out_t;

  // One classified item handed from front to back
  typedef struct packed {
    logic              clr;
    logic              drop;
    logic [SYM_W-1:0]  sym;
    logic [SYM_W-1:0]  old_sym;
    logic [FILL_W-1:0] fill;
  } swbe_op_t;

  typedef logic [DPLOG_W-1:0] dplog_tbl_t [SYMBOL_COUNT];
  typedef logic [LLR_W-1:0]   llr_tbl_t   [WINDOW_SIZE];

  // log2(k) in Q32 by repeated squaring of the mantissa
  function automatic logic [63:0] log2_q32(input logic [31:0] k);
    logic [63:0] m;
    logic [31:0] frac;
    logic [31:0] e;
    e    = '0;
    frac = '0;
    for (int i = 1; i < 32; i++) begin
      if ((k >> i) != 32'd0) e = 32'(i);
    end
    m = ({32'd0, k} << 31) >> e;
    for (int i = 0; i < 32; i++) begin
      m    = (m * m) >> 31;
      frac = {frac[30:0], 1'b0};
      if (m >= 64'h1_0000_0000) begin
        m       = m >> 1;
        frac[0] = 1'b1;
      end
    end
    if (k == 32'd0) return 64'd0;
    return {e, frac};
  endfunction

  // k*log2(k) in Q16, rounded
  function automatic logic [63:0] plog_q16(input logic [31:0] k);
    logic [63:0] p;
    p = {32'd0, k} * log2_q32(k);
    return (p + 64'd32768) >> 16;
  endfunction

  // Step of k*log2(k) from count c to c+1
  function automatic dplog_tbl_t build_dplog();
    dplog_tbl_t t;
    for (int c = 0; c < SYMBOL_COUNT; c++) begin
      t[c] = DPLOG_W'(plog_q16(32'(c + 1)) - plog_q16(32'(c)));
    end
    return t;
  endfunction

  // len*log2(len) in Q32 plus the rounding half of len*2^16, entry len-1
  function automatic llr_tbl_t build_llr();
    llr_tbl_t    t;
    logic [63:0] len;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      len  = 64'(i + 1);
      t[i] = LLR_W'(len * log2_q32(32'(i + 1)) + (len << 15));
    end
    return t;
  endfunction

  localparam dplog_tbl_t DPLOG_TBL = build_dplog();
  localparam llr_tbl_t   LLR_TBL   = build_llr();

endpackage

/* src/swbe_ram.sv */
// Generic single-write, single-read RAM with registered read data (read-before-write).
module swbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/swbe_front.sv */
// Front end: accepts beats, keeps the byte ring and fill count, fetches the byte leaving the window.
module swbe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  swbe_pkg::swbe_in_t in_i,
  output logic               q_push_o,
  output swbe_pkg::swbe_op_t q_data_o,
  input  logic               q_full_i
);
  import swbe_pkg::*;

  logic [WIN_AW-1:0] wp_q, wp_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              stg_valid_q, stg_valid_d;
  swbe_op_t          stg_q;
  logic              accept, is_clr, win_full;
  logic [SYM_W-1:0]  old_byte;

  assign is_clr   = (in_i.command == CMD_CLEAR);
  assign win_full = (fill_q == FILL_W'(WINDOW_SIZE));
  assign full_o   = stg_valid_q && q_full_i;
  assign accept   = push_i && !full_o;

  // Ring position and fill count
  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    if (accept) begin
      if (is_clr) begin
        wp_d   = '0;
        fill_d = '0;
      end else begin
        wp_d = wp_q + 1'b1;
        if (!win_full) fill_d = fill_q + 1'b1;
      end
    end
  end

  // Stage holds the beat while the leaving byte is read
  assign stg_valid_d = accept || (stg_valid_q && q_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      fill_q      <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q.clr     <= is_clr;
      stg_q.drop    <= win_full && !is_clr;
      stg_q.sym     <= in_i.data_byte;
      stg_q.old_sym <= '0;
      stg_q.fill    <= fill_d;
    end
  end

  // Byte ring: the leaving byte is read at the slot being overwritten
  swbe_ram #(
    .WIDTH(SYM_W),
    .DEPTH(WINDOW_SIZE)
  ) u_win (
    .clk_i  (clk_i),
    .we_i   (accept && !is_clr),
    .waddr_i(wp_q),
    .wdata_i(in_i.data_byte),
    .re_i   (accept && !is_clr && win_full),
    .raddr_i(wp_q),
    .rdata_o(old_byte)
  );

  // Hand off to the queue
  assign q_push_o = stg_valid_q && !q_full_i;

  always_comb begin
    q_data_o         = stg_q;
    q_data_o.old_sym = old_byte;
  end

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_clr) |=> (fill_q == '0))
    else $error("window not emptied after clear");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WINDOW_SIZE))
    else $error("fill count beyond window size");

endmodule

/* src/swbe_fifo.sv */
// Short queue of classified items between front and back.
module swbe_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  swbe_pkg::swbe_op_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output swbe_pkg::swbe_op_t data_o,
  output logic               empty_o
);
  import swbe_pkg::*;

  swbe_op_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  // Pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* src/swbe_back.sv */
// Back end: histogram update, running f*log2(f) sum, entropy division and result register.
module swbe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  swbe_pkg::swbe_op_t  q_data_i,
  output logic                q_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output swbe_pkg::swbe_out_t out_o
);
  import swbe_pkg::*;

  swbe_bk_state_e          state_q, state_d;
  swbe_op_t                op_q, op_d;
  logic [PLOG_W-1:0]       plog_q, plog_d;
  logic [SYMBOL_COUNT-1:0] hv_q, hv_d;
  logic                    rvld_q, rvld_d;
  logic                    byp_q, byp_d;
  logic [CNT_W-1:0]        bcnt_q, bcnt_d;
  logic [QUO_W-1:0]        x_q, x_d;
  logic [FILL_W-1:0]       rem_q, rem_d;
  logic [STEP_W-1:0]       step_q, step_d;
  swbe_out_t               res_q, res_d;
  logic                    res_valid_q, res_valid_d;

  logic                    h_we, h_re;
  logic [SYM_W-1:0]        h_waddr, h_raddr;
  logic [CNT_W-1:0]        h_wdata, h_rdata;
  logic [CNT_W-1:0]        cnt_cur, cnt_dec;
  logic [LLR_W-1:0]        llr;
  logic [LLR_W:0]          diff;
  logic [DIVX_W-1:0]       xval;
  logic [FILL_W+1:0]       trial;
  logic [ENT_W-1:0]        ent_sat;

  // Histogram counts
  swbe_ram #(
    .WIDTH(CNT_W),
    .DEPTH(SYMBOL_COUNT)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(h_waddr),
    .wdata_i(h_wdata),
    .re_i   (h_re),
    .raddr_i(h_raddr),
    .rdata_o(h_rdata)
  );

  // Entropy numerator and divider step
  assign llr     = LLR_TBL[WIN_AW'(op_q.fill - 1'b1)];
  assign diff    = {1'b0, llr} - {1'b0, plog_q, {FRAC_W{1'b0}}};
  assign xval    = diff[LLR_W-1:FRAC_W];
  assign trial   = {1'b0, rem_q, x_q[QUO_W-1]} - {2'b00, op_q.fill};
  assign ent_sat = (x_q > ENTROPY_MAX) ? ENTROPY_MAX : x_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    plog_d      = plog_q;
    hv_d        = hv_q;
    rvld_d      = rvld_q;
    byp_d       = byp_q;
    bcnt_d      = bcnt_q;
    x_d         = x_q;
    rem_d       = rem_q;
    step_d      = step_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !pop_i;
    q_pop_o     = 1'b0;
    h_we        = 1'b0;
    h_re        = 1'b0;
    h_waddr     = op_q.sym;
    h_raddr     = op_q.sym;
    h_wdata     = '0;
    cnt_cur     = rvld_q ? h_rdata : '0;
    cnt_dec     = '0;

    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          op_d    = q_data_i;
          byp_d   = 1'b0;
          if (q_data_i.clr) begin
            hv_d    = '0;
            plog_d  = '0;
            x_d     = '0;
            state_d = BK_FIN;
          end else begin
            h_re    = 1'b1;
            h_raddr = q_data_i.drop ? q_data_i.old_sym : q_data_i.sym;
            rvld_d  = hv_q[h_raddr];
            state_d = q_data_i.drop ? BK_OLD : BK_NEW;
          end
        end
      end

      // Remove the leaving byte, fetch the count of the new one
      BK_OLD: begin
        cnt_dec = (cnt_cur != '0) ? cnt_cur - 1'b1 : cnt_cur;
        if (cnt_cur != '0) begin
          h_we              = 1'b1;
          h_waddr           = op_q.old_sym;
          h_wdata           = cnt_dec;
          hv_d[op_q.old_sym] = 1'b1;
          plog_d            = plog_q - PLOG_W'(DPLOG_TBL[SYM_W'(cnt_dec)]);
        end
        h_re    = 1'b1;
        h_raddr = op_q.sym;
        rvld_d  = hv_q[op_q.sym];
        byp_d   = (op_q.sym == op_q.old_sym);
        bcnt_d  = cnt_dec;
        state_d = BK_NEW;
      end

      // Add the new byte
      BK_NEW: begin
        if (byp_q) cnt_cur = bcnt_q;
        h_we           = 1'b1;
        h_waddr        = op_q.sym;
        h_wdata        = cnt_cur + 1'b1;
        hv_d[op_q.sym] = 1'b1;
        plog_d         = plog_q + PLOG_W'(DPLOG_TBL[SYM_W'(cnt_cur)]);
        state_d        = BK_ENT;
      end

      // Numerator, zero if negative; full window divides by a shift
      BK_ENT: begin
        if (diff[LLR_W]) begin
          x_d     = '0;
          state_d = BK_FIN;
        end else if (op_q.fill == FILL_W'(WINDOW_SIZE)) begin
          x_d     = QUO_W'(xval >> WIN_AW);
          state_d = BK_FIN;
        end else begin
          rem_d   = {1'b0, xval[DIVX_W-1:QUO_W]};
          x_d     = xval[QUO_W-1:0];
          step_d  = STEP_W'(QUO_W - 1);
          state_d = BK_DIV;
        end
      end

      // Restoring division, one quotient bit per cycle
      BK_DIV: begin
        if (!trial[FILL_W+1]) begin
          rem_d = trial[FILL_W-1:0];
          x_d   = {x_q[QUO_W-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[FILL_W-2:0], x_q[QUO_W-1]};
          x_d   = {x_q[QUO_W-2:0], 1'b0};
        end
        if (step_q == '0) begin
          state_d = BK_FIN;
        end else begin
          step_d = step_q - 1'b1;
        end
      end

      BK_FIN: begin
        if (!res_valid_q || pop_i) begin
          res_d.entropy_q16 = ent_sat;
          res_d.window_fill = op_q.fill;
          res_valid_d       = 1'b1;
          state_d           = BK_IDLE;
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      plog_q      <= '0;
      hv_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      plog_q      <= plog_d;
      hv_q        <= hv_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    rvld_q <= rvld_d;
    byp_q  <= byp_d;
    bcnt_q <= bcnt_d;
    x_q    <= x_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    res_q  <= res_d;
  end

  assign empty_o = !res_valid_q;
  assign out_o   = res_q;

  a_ent_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.entropy_q16 <= ENTROPY_MAX))
    else $error("entropy beyond eight bits per byte");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.window_fill <= FILL_W'(1)) |-> (res_q.entropy_q16 == '0))
    else $error("nonzero entropy for fewer than two bytes");

  a_clear_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_IDLE && q_pop_o && q_data_i.clr) |=> (plog_q == '0 && hv_q == '0))
    else $error("histogram not cleared");

endmodule

/* src/sliding_window_byte_entropy.sv */
// Sliding-window byte entropy: one byte in per beat, window entropy in Q16 bits per byte out.
// Each push beat returns one result beat giving the Shannon entropy of the bytes held in a
// 256-byte ring (fewer while it fills after reset or a clear) and the fill count. A clear beat
// empties the window and returns zero. The front end takes a beat in every cycle while its
// queue has room; throughput is set by the back-end sequencer, which finishes one item before
// it takes the next. A push with a full window steps through the leaving-byte and new-byte
// histogram read-modify-write on one histogram memory, the numerator subtract, and the result
// write, since division by 256*2^16 is a shift. While the window fills the quotient comes from
// a restoring divider at one bit per cycle; the push that completes the window divides by a
// shift. A clear goes straight to the result write. Histogram bins are cleared at once by valid
// bits, so no clearing pass is needed after reset or a clear.
module sliding_window_byte_entropy (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  swbe_pkg::swbe_in_t  in_data_i,
  output logic                empty,
  input  logic                pop,
  output swbe_pkg::swbe_out_t out_data_o
);
  import swbe_pkg::*;

  logic     fq_push, fq_full, fq_pop, fq_empty;
  swbe_op_t fq_wdata, fq_rdata;

  swbe_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .in_i    (in_data_i),
    .q_push_o(fq_push),
    .q_data_o(fq_wdata),
    .q_full_i(fq_full)
  );

  swbe_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fq_push),
    .data_i (fq_wdata),
    .full_o (fq_full),
    .pop_i  (fq_pop),
    .data_o (fq_rdata),
    .empty_o(fq_empty)
  );

  swbe_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(fq_empty),
    .q_data_i (fq_rdata),
    .q_pop_o  (fq_pop),
    .empty_o  (empty),
    .pop_i    (pop),
    .out_o    (out_data_o)
  );

endmodule

/* tb/swbe_checker.sv */
// Checker for the sliding window byte entropy block: predicts every result beat and compares.
module swbe_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  logic                full,
  input  swbe_pkg::swbe_in_t  in_data_i,
  input  logic                empty,
  input  logic                pop,
  input  swbe_pkg::swbe_out_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  results_o,
  output int                  peak_hits_o
);
  import swbe_pkg::*;

  localparam int REPORT_CAP = 40;

  // log2(k) in Q32 and k*log2(k) in Q16, k = 0..WINDOW_SIZE
  logic [63:0] log2_tab [0:WINDOW_SIZE];
  logic [63:0] plog_tab [0:WINDOW_SIZE];

  // Shadow copy of the window
  logic [SYM_W-1:0] ring [WINDOW_SIZE];
  int unsigned      hist [SYMBOL_COUNT];
  int unsigned      fill;
  int unsigned      wr_pos;
  logic [63:0]      plog_total;

  swbe_out_t entropy_due [$];
  swbe_out_t want;
  int        mismatches = 0;
  int        results    = 0;
  int        peak_hits  = 0;

  // Mantissa squaring: one fraction bit per pass
  function automatic logic [63:0] calc_log2_q32(input int unsigned k);
    logic [63:0] mant;
    logic [31:0] fr;
    int unsigned ex;
    int unsigned t;
    if (k == 0) return 64'd0;
    ex = 0;
    t  = k;
    while (t > 1) begin
      t = t >> 1;
      ex++;
    end
    mant = (64'(k) << 31) >> ex;
    fr   = '0;
    for (int i = 0; i < 32; i++) begin
      mant = (mant * mant) >> 31;
      fr   = {fr[30:0], 1'b0};
      if (mant >= 64'h1_0000_0000) begin
        mant  = mant >> 1;
        fr[0] = 1'b1;
      end
    end
    return {ex[31:0], fr};
  endfunction

  initial begin
    for (int k = 0; k <= WINDOW_SIZE; k++) begin
      log2_tab[k] = calc_log2_q32(k);
      plog_tab[k] = (64'(k) * log2_tab[k] + 64'd32768) >> 16;
    end
  end

  // Apply one input beat to the shadow window and return the result it causes
  function automatic swbe_out_t advance_window(input swbe_in_t beat);
    swbe_out_t        res;
    logic [SYM_W-1:0] gone;
    logic [SYM_W-1:0] sym;
    logic [63:0]      a;
    logic [63:0]      b;
    logic [63:0]      num;
    logic [63:0]      d;
    logic [63:0]      q;
    res = '0;
    sym = beat.data_byte;
    if (beat.command == CMD_CLEAR) begin
      foreach (hist[i]) hist[i] = 0;
      fill       = 0;
      wr_pos     = 0;
      plog_total = '0;
      return res;
    end
    // full window: the oldest byte leaves first
    if (fill >= WINDOW_SIZE) begin
      gone = ring[wr_pos];
      if (hist[gone] > 0) begin
        plog_total = plog_total - (plog_tab[hist[gone]] - plog_tab[hist[gone] - 1]);
        hist[gone]--;
      end
    end
    plog_total = plog_total + (plog_tab[hist[sym] + 1] - plog_tab[hist[sym]]);
    hist[sym]++;
    ring[wr_pos] = sym;
    wr_pos = (wr_pos + 1) % WINDOW_SIZE;
    if (fill < WINDOW_SIZE) fill++;
    // log2(len) - sum/len, rounded, clamped at zero and at 8 bits
    a   = 64'(fill) * log2_tab[fill];
    b   = plog_total << 16;
    num = (a > b) ? (a - b) : 64'd0;
    d   = 64'(fill) << 16;
    q   = (num + (d >> 1)) / d;
    if (q > 64'(ENTROPY_MAX)) q = 64'(ENTROPY_MAX);
    res.entropy_q16 = ENT_W'(q);
    res.window_fill = FILL_W'(fill);
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned wanted);
    mismatches++;
    if (mismatches <= REPORT_CAP)
      $display("mismatch at result %0d: %s got %0d, predicted %0d", results, what, got, wanted);
  endtask

  // Watch both channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (hist[i]) hist[i] = 0;
      fill       = 0;
      wr_pos     = 0;
      plog_total = '0;
      entropy_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
      peak_hits_o  <= 0;
    end else begin
      // input beat taken: predict its result
      if (push && !full) entropy_due.push_back(advance_window(in_data_i));
      // result beat taken: compare with the oldest prediction
      if (pop && !empty) begin
        results++;
        if (entropy_due.size() == 0) begin
          flag_mismatch("result beat with nothing pending, entropy_q16",
                        out_data_i.entropy_q16, 0);
        end else begin
          want = entropy_due.pop_front();
          if (out_data_i.entropy_q16 != want.entropy_q16)
            flag_mismatch("entropy_q16", out_data_i.entropy_q16, want.entropy_q16);
          if (out_data_i.window_fill != want.window_fill)
            flag_mismatch("window_fill", out_data_i.window_fill, want.window_fill);
          if (want.entropy_q16 == ENTROPY_MAX) peak_hits++;
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= entropy_due.size();
      results_o    <= results;
      peak_hits_o  <= peak_hits;
    end
  end

endmodule

/* tb/tb_sliding_window_byte_entropy.sv */
// Testbench top for the sliding window byte entropy block: stimulus, clock, reset and verdict.
module tb_sliding_window_byte_entropy;
  import swbe_pkg::*;

  localparam int RANDOM_BEATS = 1650;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 60;

  logic      clk_i    = 1'b0;
  logic      rst_ni   = 1'b0;
  logic      push     = 1'b0;
  logic      pop      = 1'b0;
  swbe_in_t  in_beat  = '0;
  logic      full;
  logic      empty;
  swbe_out_t out_beat;

  logic steady = 1'b0;
  int   cycles = 0;
  int   pushes = 0;
  int   clears = 0;
  int   fail_count;
  int   pending;
  int   results;
  int   peak_hits;

  always #6 clk_i = ~clk_i;

  sliding_window_byte_entropy dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_beat),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_beat)
  );

  swbe_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_data_i    (in_beat),
    .empty        (empty),
    .pop          (pop),
    .out_data_i   (out_beat),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .peak_hits_o  (peak_hits)
  );

  // Cycle count and run limit
  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("run limit of %0d cycles reached, %0d results still pending", CYCLE_LIMIT, pending);
    $display("TB_ERROR");
    $finish;
  end

  // Result side: stalls at random except during the steady stretch
  always @(posedge clk_i) begin
    if (rst_ni) pop <= steady || ($urandom_range(99) >= 21);
  end

  // Offer one beat, with random idle cycles ahead of it, and wait until it is taken
  task automatic send_beat(input logic cmd, input logic [7:0] b);
    while (!steady && $urandom_range(99) < 21) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push              <= 1'b1;
    in_beat.command   <= cmd;
    in_beat.data_byte <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (cmd == CMD_CLEAR) clears++;
    else pushes++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    send_beat(CMD_PUSH, b);
  endtask

  initial begin
    int         sent;
    int         seg;
    int         kind;
    int         len;
    int         start;
    int         step;
    logic [7:0] pal [4];

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single byte, two distinct, extremes, uniform runs, clears
    push_byte(8'h00);
    push_byte(8'hFF);
    repeat (3) push_byte(8'h00);
    send_beat(CMD_CLEAR, 8'hFF);
    send_beat(CMD_CLEAR, 8'h00);
    push_byte(8'hA5);
    push_byte(8'h5A);
    push_byte(8'h80);
    push_byte(8'h01);
    push_byte(8'h7F);
    push_byte(8'hFE);
    send_beat(CMD_CLEAR, 8'h5A);
    repeat (6) push_byte(8'h3C);
    push_byte(8'hC3);
    send_beat(CMD_CLEAR, 8'hC3);
    push_byte(8'h42);

    // Random: segments of well-formed content, some noise with clears
    sent = 0;
    seg  = 0;
    while (sent < RANDOM_BEATS) begin
      steady <= (seg == 3);
      // the steady stretch always gets a long segment
      kind = (seg == 3) ? 0 : $urandom_range(4);
      case (kind)
        0: begin
          len = $urandom_range(400, 256);
          repeat (len) push_byte(8'($urandom));
        end
        1: begin
          // odd stride over all byte values: every value once, peak entropy
          start = $urandom_range(255);
          step  = 2 * $urandom_range(127) + 1;
          len   = 256 + $urandom_range(64);
          for (int i = 0; i < len; i++) push_byte(8'(start + i * step));
        end
        2: begin
          foreach (pal[i]) pal[i] = 8'($urandom);
          len = $urandom_range(300, 50);
          repeat (len) push_byte(pal[$urandom_range(3)]);
        end
        3: begin
          start = $urandom_range(255);
          len   = $urandom_range(300, 20);
          repeat (len) push_byte(8'(start));
        end
        default: begin
          len = $urandom_range(20, 1);
          repeat (len) begin
            if ($urandom_range(99) < 30) send_beat(CMD_CLEAR, 8'($urandom));
            else push_byte(8'($urandom));
          end
        end
      endcase
      sent += len;
      if ($urandom_range(4) == 0) begin
        send_beat(CMD_CLEAR, 8'($urandom));
        sent++;
      end
      seg++;
    end
    steady <= 1'b0;
    push   <= 1'b0;
    @(posedge clk_i);

    // Drain, then a quiet tail for stray beats
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d pushes and %0d clears in %0d segments, %0d results checked",
             pushes, clears, seg, results);
    $display("%0d results at peak entropy, %0d mismatches", peak_hits, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/swbe_pkg.sv
src/swbe_ram.sv
src/swbe_front.sv
src/swbe_fifo.sv
src/swbe_back.sv
src/sliding_window_byte_entropy.sv
tb/swbe_checker.sv
tb/tb_sliding_window_byte_entropy.sv
